@@ rtl/spam_pkg.sv @@
// ----------------------------------------------------------------------------
// spam_pkg
// Shared types and codes for the sparse polynomial add/merge unit.
// ----------------------------------------------------------------------------
package spam_pkg;

	// Command carried in the mode field of an input request
	typedef enum logic [1:0] {
		MODE_LOAD_FIRST  = 2'd0,
		MODE_LOAD_SECOND = 2'd1,
		MODE_ADD         = 2'd2,
		MODE_CLEAR       = 2'd3
	} mode_t;

	// Control sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	localparam int COEFF_W = 16;
	localparam int POWER_W = 8;
	localparam int SUM_W   = 17;

	// One stored term
	typedef struct packed {
		logic signed [COEFF_W-1:0] coeff;
		logic        [POWER_W-1:0] power;
	} term_t;

endpackage

@@ rtl/spam_in_if.sv @@
// ----------------------------------------------------------------------------
// spam_in_if
// Input request channel: command plus one term (coefficient, power).
// ----------------------------------------------------------------------------
interface spam_in_if;
	logic                                valid;
	logic                                ready;
	spam_pkg::mode_t                     mode;
	logic signed [spam_pkg::COEFF_W-1:0] coeff;
	logic        [spam_pkg::POWER_W-1:0] power;

	modport source (output valid, mode, coeff, power, input ready);
	modport sink   (input valid, mode, coeff, power, output ready);
endinterface

@@ rtl/spam_out_if.sv @@
// ----------------------------------------------------------------------------
// spam_out_if
// Result channel: one merged term per transfer, last marks the final term.
// ----------------------------------------------------------------------------
interface spam_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [spam_pkg::SUM_W-1:0]   sum_coeff;
	logic        [spam_pkg::POWER_W-1:0] sum_power;
	logic                                last;

	modport source (output valid, sum_coeff, sum_power, last, input ready);
	modport sink   (input valid, sum_coeff, sum_power, last, output ready);
endinterface

@@ rtl/sparse_polynomial_add_merge_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_add_merge_unit
// Two term stores loaded one term per request; an add request merges them
// by descending power and streams the merged terms out.
// ----------------------------------------------------------------------------
// Load and clear requests give no result. An add request streams out one
// merged term per cycle while the output is not stalled, that is
// first_count + second_count - (number of equal-power pairs) terms, at
// most 2*TERM_DEPTH; an add with both stores empty gives no result. The
// merge rate is set by the single read port of each term memory: each
// cycle reads the next entry of each store, chosen from the comparison
// made on the entries read the cycle before. No new request is taken while
// a merge is running. Stores keep their contents after an add; loads into
// a full store are dropped.
module sparse_polynomial_add_merge_unit #(
	parameter int TERM_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	spam_in_if.sink    term_in,
	spam_out_if.source term_out
);
	import spam_pkg::*;

	localparam int CW = $clog2(TERM_DEPTH + 1);
	localparam int AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TERM_DEPTH);

	// Term memories
	term_t mem_first  [TERM_DEPTH];
	term_t mem_second [TERM_DEPTH];

	term_t rd_first_q;
	term_t rd_second_q;

	state_t state_q, state_nxt;

	logic [CW-1:0] first_count_q, second_count_q;
	logic [CW-1:0] a_q, b_q;
	logic [CW-1:0] a_adv, b_adv, a_nxt, b_nxt;
	logic [AW-1:0] a_raddr, b_raddr;

	logic out_valid_q;
	logic signed [SUM_W-1:0] out_coeff_q;
	logic [POWER_W-1:0] out_power_q;
	logic out_last_q;

	logic in_ready, in_acc;
	logic have_a, have_b, take_a, take_b;
	logic slot_free, emit, last_term;
	logic wr_first, wr_second;
	logic signed [SUM_W-1:0] term_coeff;
	logic [POWER_W-1:0] term_power;

	// Port drive
	assign term_in.ready      = in_ready;
	assign term_out.valid     = out_valid_q;
	assign term_out.sum_coeff = out_coeff_q;
	assign term_out.sum_power = out_power_q;
	assign term_out.last      = out_last_q;

	// Merge selection from the entries read last cycle
	always_comb begin
		have_a = (a_q < first_count_q);
		have_b = (b_q < second_count_q);
		take_a = have_a && (!have_b || (rd_first_q.power >= rd_second_q.power));
		take_b = have_b && (!have_a || (rd_second_q.power >= rd_first_q.power));
		a_adv  = a_q + CW'(take_a);
		b_adv  = b_q + CW'(take_b);
		last_term = (a_adv >= first_count_q) && (b_adv >= second_count_q);
		if (take_a && take_b) begin
			term_coeff = SUM_W'(rd_first_q.coeff) + SUM_W'(rd_second_q.coeff);
		end else if (take_a) begin
			term_coeff = SUM_W'(rd_first_q.coeff);
		end else begin
			term_coeff = SUM_W'(rd_second_q.coeff);
		end
		term_power = take_a ? rd_first_q.power : rd_second_q.power;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && term_in.mode == MODE_ADD &&
				    (first_count_q != '0 || second_count_q != '0)) begin
					state_nxt = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (emit && last_term) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		slot_free = !out_valid_q || term_out.ready;
		in_ready  = 1'b0;
		emit      = 1'b0;
		a_nxt     = '0;
		b_nxt     = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MERGE: begin
				emit  = slot_free && (have_a || have_b);
				a_nxt = emit ? a_adv : a_q;
				b_nxt = emit ? b_adv : b_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		in_acc    = in_ready && term_in.valid;
		wr_first  = in_acc && term_in.mode == MODE_LOAD_FIRST && first_count_q < DEPTH_C;
		wr_second = in_acc && term_in.mode == MODE_LOAD_SECOND && second_count_q < DEPTH_C;
		a_raddr   = (a_nxt < DEPTH_C) ? a_nxt[AW-1:0] : '0;
		b_raddr   = (b_nxt < DEPTH_C) ? b_nxt[AW-1:0] : '0;
	end

	// Memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (wr_first) begin
			mem_first[first_count_q[AW-1:0]] <= '{coeff: term_in.coeff, power: term_in.power};
		end
		rd_first_q <= mem_first[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr_second) begin
			mem_second[second_count_q[AW-1:0]] <= '{coeff: term_in.coeff,
			                                        power: term_in.power};
		end
		rd_second_q <= mem_second[b_raddr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			first_count_q  <= '0;
			second_count_q <= '0;
			a_q            <= '0;
			b_q            <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			a_q     <= a_nxt;
			b_q     <= b_nxt;
			if (wr_first) begin
				first_count_q <= first_count_q + CW'(1);
			end
			if (wr_second) begin
				second_count_q <= second_count_q + CW'(1);
			end
			if (in_acc && term_in.mode == MODE_CLEAR) begin
				first_count_q  <= '0;
				second_count_q <= '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (term_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_coeff_q <= term_coeff;
			out_power_q <= term_power;
			out_last_q  <= last_term;
		end
	end

	// Checks
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> (a_q <= first_count_q && b_q <= second_count_q))
		else $error("merge index past store count");

	count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_count_q <= DEPTH_C && second_count_q <= DEPTH_C)
		else $error("store count past depth");

	last_ends_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_term) |=> (state_q == ST_IDLE && out_valid_q && out_last_q))
		else $error("final term did not end the merge");

	merge_progress: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> (have_a || have_b))
		else $error("merge running with both stores exhausted");

	hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && !emit) |=> ($stable(a_q) && $stable(b_q)))
		else $error("merge index moved without a result");

endmodule
